// ===== hdl/cnsp_pkg.sv =====
// Shared types, constants and helpers for the cpio newc stream parser.
// No dependencies; used by every module under hdl/.
`default_nettype none

package cnsp_pkg;

    // Default widths for the top-level parameters
    localparam int ENTRY_INDEX_BITS_DEF = 16;
    localparam int SIZE_BITS_DEF        = 32;

    // Fixed newc header layout
    localparam int HDR_LEN     = 110;
    localparam int MAGIC_LEN   = 6;
    localparam int FSZ_POS     = 54;
    localparam int NSZ_POS     = 94;
    localparam int FIELD_LEN   = 8;
    localparam int TRAILER_LEN = 11;
    localparam int MIN_NAME    = 2;

    // ASCII characters used by the hex field parser
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [4:0] HEX_TEN  = 5'd10;
    localparam logic [4:0] HEX_NONE = 5'd16;

    // Expected magic "070701" and trailer name "TRAILER!!!" with its terminator
    localparam logic [7:0] MAGIC_CHARS [MAGIC_LEN] = '{
        8'h30, 8'h37, 8'h30, 8'h37, 8'h30, 8'h31
    };
    localparam logic [7:0] TRAILER_CHARS [TRAILER_LEN] = '{
        8'h54, 8'h52, 8'h41, 8'h49, 8'h4C, 8'h45, 8'h52, 8'h21, 8'h21, 8'h21, 8'h00
    };

    // Byte classification
    typedef enum logic [2:0] {
        REG_HEADER   = 3'd0,
        REG_NAME     = 3'd1,
        REG_NAME_PAD = 3'd2,
        REG_DATA     = 3'd3,
        REG_DATA_PAD = 3'd4,
        REG_IGNORED  = 3'd5
    } region_t;

    // Sticky error codes
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_MAGIC     = 2'd1,
        ERR_NAME_SIZE = 2'd2
    } error_t;

    // Control from the entry tracker to the hex field parser
    typedef struct packed {
        logic advance;   // item accepted this cycle
        logic active;    // byte lies inside a size field
        logic clear;     // byte is the first of a size field
        logic restart;   // entry ends with this byte
    } fld_ctrl_t;

    // Hex digit value, or HEX_NONE for a non-hex character
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] d;
        d = HEX_NONE;
        if (b inside {[CH_0:CH_9]}) begin
            d = 5'(b - CH_0);
        end else if (b inside {[CH_UA:CH_UF]}) begin
            d = 5'(b - CH_UA) + HEX_TEN;
        end else if (b inside {[CH_LA:CH_LF]}) begin
            d = 5'(b - CH_LA) + HEX_TEN;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cnsp_field.sv =====
// Hex size field accumulator: skips leading blanks and zeros, stops at the
// first non-hex character. Depends on cnsp_pkg.
`default_nettype none

module cnsp_field #(
    parameter int SIZE_BITS = cnsp_pkg::SIZE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cnsp_pkg::fld_ctrl_t   ctrl,
    input  wire logic [7:0]            data_byte,
    output logic      [SIZE_BITS-1:0]  acc_value
);

    logic [SIZE_BITS-1:0] acc_reg;
    logic                 started_reg;
    logic                 stopped_reg;
    logic [SIZE_BITS-1:0] base_acc;
    logic                 base_started;
    logic                 base_stopped;
    logic                 started_next;
    logic                 stopped_next;
    logic [4:0]           digit;

    // Fold this byte into the field value
    always_comb begin
        base_acc     = ctrl.clear ? '0 : acc_reg;
        base_started = ctrl.clear ? 1'b0 : started_reg;
        base_stopped = ctrl.clear ? 1'b0 : stopped_reg;
        acc_value    = base_acc;
        started_next = base_started;
        stopped_next = base_stopped;
        digit        = cnsp_pkg::hex_digit(data_byte);
        if (ctrl.active && !base_stopped) begin
            if (base_started ||
                (data_byte != cnsp_pkg::CH_SPACE && data_byte != cnsp_pkg::CH_0)) begin
                started_next = 1'b1;
                if (digit == cnsp_pkg::HEX_NONE) begin
                    stopped_next = 1'b1;
                end else begin
                    acc_value = {base_acc[SIZE_BITS-5:0], digit[3:0]};
                end
            end
        end
    end

    // Hold field state between items; clear at entry end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            started_reg <= 1'b0;
            stopped_reg <= 1'b0;
        end else if (ctrl.advance) begin
            if (ctrl.restart) begin
                acc_reg     <= '0;
                started_reg <= 1'b0;
                stopped_reg <= 1'b0;
            end else begin
                acc_reg     <= acc_value;
                started_reg <= started_next;
                stopped_reg <= stopped_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cnsp_tracker.sv =====
// Entry tracker: region and offset walk, magic and trailer checks, sizes,
// errors and entry count. Depends on cnsp_pkg and cnsp_field.
`default_nettype none

module cnsp_tracker #(
    parameter int ENTRY_INDEX_BITS = cnsp_pkg::ENTRY_INDEX_BITS_DEF,
    parameter int SIZE_BITS        = cnsp_pkg::SIZE_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        advance,
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        archive_last,
    output cnsp_pkg::region_t                region,
    output logic      [ENTRY_INDEX_BITS-1:0] entry_index,
    output logic      [SIZE_BITS-1:0]        name_length,
    output logic      [SIZE_BITS-1:0]        file_length,
    output logic                             entry_end,
    output logic                             is_trailer,
    output cnsp_pkg::error_t                 error_code,
    output logic                             archive_done
);

    localparam logic [SIZE_BITS-1:0] OFF_MAGIC_END = SIZE_BITS'(cnsp_pkg::MAGIC_LEN - 1);
    localparam logic [SIZE_BITS-1:0] OFF_MAGIC_LIM = SIZE_BITS'(cnsp_pkg::MAGIC_LEN);
    localparam logic [SIZE_BITS-1:0] OFF_FSZ_FIRST = SIZE_BITS'(cnsp_pkg::FSZ_POS);
    localparam logic [SIZE_BITS-1:0] OFF_FSZ_LAST  =
        SIZE_BITS'(cnsp_pkg::FSZ_POS + cnsp_pkg::FIELD_LEN - 1);
    localparam logic [SIZE_BITS-1:0] OFF_NSZ_FIRST = SIZE_BITS'(cnsp_pkg::NSZ_POS);
    localparam logic [SIZE_BITS-1:0] OFF_NSZ_LAST  =
        SIZE_BITS'(cnsp_pkg::NSZ_POS + cnsp_pkg::FIELD_LEN - 1);
    localparam logic [SIZE_BITS-1:0] OFF_TRL_LIM   = SIZE_BITS'(cnsp_pkg::TRAILER_LEN);
    localparam logic [SIZE_BITS-1:0] OFF_TRL_LAST  = SIZE_BITS'(cnsp_pkg::TRAILER_LEN - 1);
    localparam logic [SIZE_BITS-1:0] LEN_HEADER    = SIZE_BITS'(cnsp_pkg::HDR_LEN);
    localparam logic [SIZE_BITS-1:0] LEN_MIN_NAME  = SIZE_BITS'(cnsp_pkg::MIN_NAME);
    localparam logic [1:0]           HDR_PHASE     = 2'(cnsp_pkg::HDR_LEN);

    cnsp_pkg::region_t             region_reg,  region_next;
    logic [SIZE_BITS-1:0]          offset_reg,  offset_next;
    logic [SIZE_BITS-1:0]          name_reg,    name_next;
    logic [SIZE_BITS-1:0]          file_reg,    file_next;
    logic [ENTRY_INDEX_BITS-1:0]   entry_reg,   entry_next;
    logic                          magic_reg,   magic_next;
    logic                          trailer_reg, trailer_next;
    cnsp_pkg::error_t              error_reg,   error_next;
    logic                          done_reg,    done_next;

    cnsp_pkg::fld_ctrl_t           fld_ctrl;
    logic [SIZE_BITS-1:0]          acc_value;
    logic                          active;
    logic                          in_header;
    logic                          seen_full;
    logic                          trl;
    logic [1:0]                    name_pad;
    logic [1:0]                    data_pad;
    logic [4:1]                    nonempty;
    logic [SIZE_BITS-1:0]          region_len;
    logic [SIZE_BITS:0]            offset_inc;
    logic                          region_done;
    logic                          found;
    cnsp_pkg::region_t             later_region;
    logic                          end_of_entry;

    // Size field parser
    cnsp_field #(
        .SIZE_BITS (SIZE_BITS)
    ) u_field (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (fld_ctrl),
        .data_byte (data_byte),
        .acc_value (acc_value)
    );

    assign active    = (error_reg == cnsp_pkg::ERR_NONE) && !done_reg;
    assign in_header = active && (region_reg == cnsp_pkg::REG_HEADER);

    // Steer the size field parser
    always_comb begin
        fld_ctrl.advance = advance;
        fld_ctrl.clear   = in_header &&
                           (offset_reg == OFF_FSZ_FIRST || offset_reg == OFF_NSZ_FIRST);
        fld_ctrl.active  = in_header &&
                           ((offset_reg >= OFF_FSZ_FIRST && offset_reg <= OFF_FSZ_LAST) ||
                            (offset_reg >= OFF_NSZ_FIRST && offset_reg <= OFF_NSZ_LAST));
        fld_ctrl.restart = end_of_entry;
    end

    // Header checks and size capture
    always_comb begin
        magic_next = magic_reg;
        error_next = error_reg;
        file_next  = file_reg;
        name_next  = name_reg;
        if (in_header && offset_reg < OFF_MAGIC_LIM &&
            data_byte != cnsp_pkg::MAGIC_CHARS[offset_reg[2:0]]) begin
            magic_next = 1'b0;
        end
        if (in_header && offset_reg == OFF_MAGIC_END && !magic_next) begin
            error_next = cnsp_pkg::ERR_MAGIC;
        end
        if (in_header && offset_reg == OFF_FSZ_LAST) begin
            file_next = acc_value;
        end
        if (in_header && offset_reg == OFF_NSZ_LAST) begin
            name_next = acc_value;
            if (acc_value < LEN_MIN_NAME && error_next == cnsp_pkg::ERR_NONE) begin
                error_next = cnsp_pkg::ERR_NAME_SIZE;
            end
        end
    end

    // Trailer name match
    always_comb begin
        trailer_next = trailer_reg;
        seen_full    = 1'b0;
        if (active && region_reg == cnsp_pkg::REG_NAME && offset_reg < OFF_TRL_LIM &&
            data_byte != cnsp_pkg::TRAILER_CHARS[offset_reg[3:0]]) begin
            trailer_next = 1'b0;
        end
        case (region_reg)
            cnsp_pkg::REG_NAME: begin
                seen_full = offset_reg >= OFF_TRL_LAST;
            end
            cnsp_pkg::REG_NAME_PAD, cnsp_pkg::REG_DATA, cnsp_pkg::REG_DATA_PAD: begin
                seen_full = name_reg >= OFF_TRL_LIM;
            end
            default: begin
                seen_full = 1'b0;
            end
        endcase
        trl = active && trailer_next && seen_full;
    end

    // Region lengths and the next non-empty region
    always_comb begin
        name_pad    = 2'd0 - (HDR_PHASE + name_next[1:0]);
        data_pad    = 2'd0 - file_next[1:0];
        nonempty[1] = name_next != '0;
        nonempty[2] = name_pad != 2'd0;
        nonempty[3] = file_next != '0;
        nonempty[4] = data_pad != 2'd0;
        case (region_reg)
            cnsp_pkg::REG_HEADER:   region_len = LEN_HEADER;
            cnsp_pkg::REG_NAME:     region_len = name_next;
            cnsp_pkg::REG_NAME_PAD: region_len = SIZE_BITS'(name_pad);
            cnsp_pkg::REG_DATA:     region_len = file_next;
            cnsp_pkg::REG_DATA_PAD: region_len = SIZE_BITS'(data_pad);
            default:                region_len = '0;
        endcase
        offset_inc   = {1'b0, offset_reg} + 1'b1;
        region_done  = offset_inc >= {1'b0, region_len};
        found        = 1'b0;
        later_region = cnsp_pkg::REG_HEADER;
        for (int i = 1; i <= 4; i++) begin
            if (!found && 3'(i) > region_reg && nonempty[i]) begin
                found        = 1'b1;
                later_region = cnsp_pkg::region_t'(3'(i));
            end
        end
    end

    // Advance offset and region; close the entry after its last region
    always_comb begin
        region_next  = region_reg;
        offset_next  = offset_reg;
        entry_next   = entry_reg;
        done_next    = done_reg;
        end_of_entry = 1'b0;
        if (active && error_next == cnsp_pkg::ERR_NONE) begin
            if (region_done) begin
                offset_next = '0;
                if (found) begin
                    region_next = later_region;
                end else begin
                    end_of_entry = 1'b1;
                    region_next  = cnsp_pkg::REG_HEADER;
                    if (trl) begin
                        done_next = 1'b1;
                    end
                    if (entry_reg != '1) begin
                        entry_next = entry_reg + 1'b1;
                    end
                end
            end else begin
                offset_next = offset_inc[SIZE_BITS-1:0];
            end
        end
        if (archive_last) begin
            done_next = 1'b1;
        end
    end

    // Hold tracker state between items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_reg  <= cnsp_pkg::REG_HEADER;
            offset_reg  <= '0;
            name_reg    <= '0;
            file_reg    <= '0;
            entry_reg   <= '0;
            magic_reg   <= 1'b1;
            trailer_reg <= 1'b1;
            error_reg   <= cnsp_pkg::ERR_NONE;
            done_reg    <= 1'b0;
        end else if (advance) begin
            region_reg <= region_next;
            offset_reg <= offset_next;
            entry_reg  <= entry_next;
            error_reg  <= error_next;
            done_reg   <= done_next;
            if (end_of_entry) begin
                name_reg    <= '0;
                file_reg    <= '0;
                magic_reg   <= 1'b1;
                trailer_reg <= 1'b1;
            end else begin
                name_reg    <= name_next;
                file_reg    <= file_next;
                magic_reg   <= magic_next;
                trailer_reg <= trailer_next;
            end
        end
    end

    // Result fields for this item
    assign region       = active ? region_reg : cnsp_pkg::REG_IGNORED;
    assign entry_index  = entry_reg;
    assign name_length  = name_next;
    assign file_length  = file_next;
    assign entry_end    = end_of_entry;
    assign is_trailer   = trl;
    assign error_code   = error_next;
    assign archive_done = done_next;

endmodule

`default_nettype wire

// ===== hdl/cpio_newc_stream_parser.sv =====
// Channel  Dir  Ports          Item
// s_       in   tdata, tlast   tdata[7:0] data_byte; tlast archive_last
// m_       out  tdata, tuser,  tdata byte_value/entry_index/name_length/file_length/
//                tlast          is_trailer/error_code/archive_done; tuser region; tlast entry_end
//
// One item per cycle while m_tready is high; each result appears the cycle after its input.
// All per-byte work is one combinational pass from the tracker state into the result
// register. s_tready is low only while the result register is full and m_tready is low.
// aresetn (synchronous, active low) returns the parser to the start of an archive.
// Top level of the cpio newc stream parser; depends on cnsp_pkg, cnsp_tracker, cnsp_field.
`default_nettype none

module cpio_newc_stream_parser #(
    parameter int ENTRY_INDEX_BITS = cnsp_pkg::ENTRY_INDEX_BITS_DEF,
    parameter int SIZE_BITS        = cnsp_pkg::SIZE_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // data_byte
    input  wire logic       s_tlast,   // archive_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    // byte_value, entry_index, name_length, file_length, is_trailer, error_code,
    // archive_done, zero fill
    output logic [((8 + ENTRY_INDEX_BITS + 2 * SIZE_BITS + 4 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [2:0]      m_tuser,   // region
    output logic            m_tlast    // entry_end
);

    localparam int PACK_W = 8 + ENTRY_INDEX_BITS + 2 * SIZE_BITS + 4;
    localparam int DATA_W = ((PACK_W + 7) / 8) * 8;

    logic                        accept;
    logic                        m_tvalid_reg;
    logic [DATA_W-1:0]           m_tdata_reg;
    logic [2:0]                  m_tuser_reg;
    logic                        m_tlast_reg;

    cnsp_pkg::region_t           region;
    logic [ENTRY_INDEX_BITS-1:0] entry_index;
    logic [SIZE_BITS-1:0]        name_length;
    logic [SIZE_BITS-1:0]        file_length;
    logic                        entry_end;
    logic                        is_trailer;
    cnsp_pkg::error_t            error_code;
    logic                        archive_done;

    // Take a new item whenever the result register is free or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    cnsp_tracker #(
        .ENTRY_INDEX_BITS (ENTRY_INDEX_BITS),
        .SIZE_BITS        (SIZE_BITS)
    ) u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept),
        .data_byte    (s_tdata),
        .archive_last (s_tlast),
        .region       (region),
        .entry_index  (entry_index),
        .name_length  (name_length),
        .file_length  (file_length),
        .entry_end    (entry_end),
        .is_trailer   (is_trailer),
        .error_code   (error_code),
        .archive_done (archive_done)
    );

    // Result register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Capture the result item
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= DATA_W'({archive_done, error_code, is_trailer,
                                    file_length, name_length, entry_index, s_tdata});
            m_tuser_reg <= region;
            m_tlast_reg <= entry_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire
